>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: default screen size,
// operation codes, control bytes and cell values.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;

	// operation codes carried on kind
	localparam logic [2:0] KIND_PUT   = 3'd0;
	localparam logic [2:0] KIND_CLEAR = 3'd1;
	localparam logic [2:0] KIND_GOTO  = 3'd2;
	localparam logic [2:0] KIND_ATTR  = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	// control bytes
	localparam logic [7:0] CH_NEWLINE   = 8'h0a;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_BLANK     = 8'h20;

	localparam logic [7:0] ATTR_RESET = 8'h07;
	localparam logic [7:0] ATTR_BLANK = 8'h1f;
	localparam logic [15:0] BLANK_CELL = {ATTR_BLANK, CH_BLANK};

	localparam logic [7:0] TAB_STEP = 8'd4;

	typedef logic [15:0] cell_t;

endpackage

>>> rtl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell console engine: screen store of char/attribute cells in one
// synchronous RAM, cursor, current attribute, scroll and clear sweeps.
// ----------------------------------------------------------------------------
// Usage: a command transfer happens on a rising edge with start high and busy
// low. Each command gives exactly one result, shown for a single cycle with
// done high; the receiver cannot stall it, so capture it on that edge.
// Completion: goto, set attribute, and plain characters, newline and tab that
// do not scroll show done in the cycle after the accepting edge; backspace
// away from column 0 and read cell go through one RAM read, registered;
// clear writes one cell per cycle over the whole screen; a put char that
// runs past the last row scrolls: the copy sweep moves one cell per cycle
// through the single read and single write port of the screen RAM, then the
// bottom row is blanked one cell per cycle. busy is high throughout. The
// next command may be started in the done cycle itself.
// Screen cells hold nothing defined after reset; read cells only after clear.
// ----------------------------------------------------------------------------
module text_console_writer_core
	import tcw_pkg::*;
#(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] kind,
	input  logic [7:0] char_code,
	input  logic [6:0] target_col,
	input  logic [4:0] target_row,
	input  logic [7:0] new_attr,
	output logic       done,
	output logic [6:0] cursor_col,
	output logic [4:0] cursor_row,
	output logic       did_scroll,
	output logic [7:0] cell_char,
	output logic [7:0] cell_attr
);

	localparam int DEPTH = COLS * ROWS;
	localparam int AW    = $clog2(DEPTH);
	// first cell of the bottom row; also the number of cells moved by a scroll
	localparam int LAST  = (ROWS - 1) * COLS;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BS_WR = 3'd1; // backspace: read data back, write blank char
	localparam logic [2:0] ST_READ  = 3'd2; // read cell: data back
	localparam logic [2:0] ST_SCRL  = 3'd3; // copy row r+1 to row r, one cell per cycle
	localparam logic [2:0] ST_DRAIN = 3'd4; // last copy write
	localparam logic [2:0] ST_FILL  = 3'd5; // blank cells up to the end of the screen

	logic [2:0]    state_q;
	logic [6:0]    col_q;
	logic [4:0]    row_q;
	logic [7:0]    attr_q;
	logic [AW-1:0] cnt_q;     // sweep pointer
	logic [AW-1:0] addr_q;    // cell address held for backspace write
	logic          scr_q;     // this command scrolled
	logic          done_q;
	logic          scroll_q;
	logic [7:0]    cchar_q;
	logic [7:0]    cattr_q;

	// copy pipeline: read issued at cnt+COLS, written in the following cycle at cnt
	logic          vld_s1;
	logic [AW-1:0] p_s1;

	// screen RAM
	cell_t         mem [DEPTH];
	cell_t         mem_rdata;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	cell_t         mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	logic          accept;
	logic [6:0]    tcol_sat;
	logic [4:0]    trow_sat;
	logic [AW-1:0] cur_idx;
	logic [AW-1:0] bs_idx;
	logic [AW-1:0] rd_idx;
	logic [7:0]    col_tab;   // column plus tab step, may pass COLS
	logic [7:0]    col_inc;   // column plus one, may reach COLS
	logic          is_plain;
	logic          at_bottom;

	function automatic logic [AW-1:0] cell_idx(input logic [6:0] c, input logic [4:0] r);
		cell_idx = AW'(AW'(r) * AW'(COLS) + AW'(c));
	endfunction

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign tcol_sat  = (int'(target_col) >= COLS) ? 7'(COLS - 1) : target_col;
	assign trow_sat  = (int'(target_row) >= ROWS) ? 5'(ROWS - 1) : target_row;
	assign cur_idx   = cell_idx(col_q, row_q);
	assign bs_idx    = cell_idx(col_q - 7'd1, row_q);
	assign rd_idx    = cell_idx(tcol_sat, trow_sat);
	assign col_tab   = {1'b0, col_q} + TAB_STEP;
	assign col_inc   = {1'b0, col_q} + 8'd1;
	assign is_plain  = (char_code != CH_NEWLINE) && (char_code != CH_TAB) &&
	                   (char_code != CH_BACKSPACE);
	assign at_bottom = (int'(row_q) + 1 >= ROWS);

	// RAM port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_idx;
		mem_wdata = {attr_q, char_code};
		mem_re    = 1'b0;
		mem_raddr = rd_idx;
		case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_PUT) begin
					if (is_plain) begin
						mem_we = 1'b1;
					end else if (char_code == CH_BACKSPACE && col_q != 7'd0) begin
						mem_re    = 1'b1;
						mem_raddr = bs_idx;
					end
				end else if (accept && kind == KIND_READ) begin
					mem_re = 1'b1;
				end
			end
			ST_BS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = {mem_rdata[15:8], CH_BLANK};
			end
			ST_SCRL: begin
				mem_re    = 1'b1;
				mem_raddr = cnt_q + AW'(COLS);
				mem_we    = vld_s1;
				mem_waddr = p_s1;
				mem_wdata = mem_rdata;
			end
			ST_DRAIN: begin
				mem_we    = 1'b1;
				mem_waddr = p_s1;
				mem_wdata = mem_rdata;
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = BLANK_CELL;
			end
			default: begin
			end
		endcase
	end

	// reads in the same cycle as a write always target a higher cell address, so no overlap
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			col_q    <= 7'd0;
			row_q    <= 5'd0;
			attr_q   <= ATTR_RESET;
			cnt_q    <= '0;
			addr_q   <= '0;
			scr_q    <= 1'b0;
			done_q   <= 1'b0;
			scroll_q <= 1'b0;
			cchar_q  <= 8'd0;
			cattr_q  <= 8'd0;
			vld_s1   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == ST_SCRL);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scroll_q <= 1'b0;
						cchar_q  <= 8'd0;
						cattr_q  <= 8'd0;
						scr_q    <= 1'b0;
						done_q   <= 1'b1;
						case (kind)
							KIND_PUT: begin
								if (char_code == CH_BACKSPACE) begin
									if (col_q != 7'd0) begin
										col_q   <= col_q - 7'd1;
										addr_q  <= bs_idx;
										done_q  <= 1'b0;
										state_q <= ST_BS_WR;
									end
								end else if (char_code == CH_TAB && int'(col_tab) < COLS) begin
									col_q <= col_tab[6:0];
								end else if (is_plain && int'(col_inc) < COLS) begin
									col_q <= col_inc[6:0];
								end else begin
									// newline, or tab / character wrap
									col_q <= 7'd0;
									if (at_bottom) begin
										scr_q   <= 1'b1;
										cnt_q   <= '0;
										done_q  <= 1'b0;
										state_q <= ST_SCRL;
									end else begin
										row_q <= row_q + 5'd1;
									end
								end
							end
							KIND_CLEAR: begin
								attr_q  <= ATTR_BLANK;
								col_q   <= 7'd0;
								row_q   <= 5'd0;
								cnt_q   <= '0;
								done_q  <= 1'b0;
								state_q <= ST_FILL;
							end
							KIND_GOTO: begin
								col_q <= tcol_sat;
								row_q <= trow_sat;
							end
							KIND_ATTR: begin
								attr_q <= new_attr;
							end
							KIND_READ: begin
								done_q  <= 1'b0;
								state_q <= ST_READ;
							end
							default: begin
							end
						endcase
					end
				end
				ST_BS_WR: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					cchar_q <= mem_rdata[7:0];
					cattr_q <= mem_rdata[15:8];
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCRL: begin
					if (cnt_q == AW'(LAST - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					cnt_q   <= AW'(LAST);
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					if (cnt_q == AW'(DEPTH - 1)) begin
						scroll_q <= scr_q;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign cursor_col = col_q;
	assign cursor_row = row_q;
	assign did_scroll = scroll_q;
	assign cell_char  = cchar_q;
	assign cell_attr  = cattr_q;

endmodule

>>> rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer core.
// ----------------------------------------------------------------------------
module tcw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [6:0] cursor_col,
	input logic       did_scroll,
	input logic [7:0] cell_char,
	input logic [7:0] cell_attr
);

	// a result only follows a transfer or a busy period
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start) || $past(busy)))
		else $error("done without a command");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a transfer");

	a_scroll_col: assert property (@(posedge clk) disable iff (!arst_n)
		(done && did_scroll) |-> (cursor_col == 7'd0 && cell_char == 8'd0 &&
		cell_attr == 8'd0))
		else $error("bad result after scroll");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.cursor_col (cursor_col),
	.did_scroll (did_scroll),
	.cell_char  (cell_char),
	.cell_attr  (cell_attr)
);
